@@ hw/rtl/yrgb_pkg.sv @@
// ---------------------------------------------------------------------------
// yrgb_pkg
// Shared types and constants for the YUYV 4:2:2 to RGB converter.
// ---------------------------------------------------------------------------
package yrgb_pkg;

   // output_mode register codes
   localparam logic [1:0] MODE_PASS  = 2'd0;
   localparam logic [1:0] MODE_RGB   = 2'd1;
   localparam logic [1:0] MODE_GRAY  = 2'd2;
   localparam logic [1:0] MODE_RESET = MODE_RGB;

   // meaningful byte counts per mode
   localparam logic [2:0] COUNT_PASS = 3'd4;
   localparam logic [2:0] COUNT_RGB  = 3'd6;
   localparam logic [2:0] COUNT_GRAY = 3'd2;
   localparam logic [2:0] COUNT_NONE = 3'd0;

   // BT.601 integer transform
   localparam int SUM_W = 19;                     // signed width of products and sums
   localparam logic signed [8:0] LUMA_OFS   = 9'sd16;
   localparam logic signed [8:0] CHROMA_OFS = 9'sd128;
   localparam logic signed [SUM_W-1:0] K_Y    = 19'sd298;
   localparam logic signed [SUM_W-1:0] K_VR   = 19'sd409;
   localparam logic signed [SUM_W-1:0] K_UG   = 19'sd100;
   localparam logic signed [SUM_W-1:0] K_VG   = 19'sd208;
   localparam logic signed [SUM_W-1:0] K_UB   = 19'sd516;
   localparam logic signed [SUM_W-1:0] ROUND  = 19'sd128;
   localparam logic [7:0] CHAN_MAX = 8'd255;

   // one YUYV macropixel
   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
      logic       frame_end;
   } yrgb_req_type;

   // one result
   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic [7:0] out_byte4;
      logic [7:0] out_byte5;
      logic [2:0] valid_count;
      logic       frame_last;
   } yrgb_rsp_type;

   // R, G, B of one pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } yrgb_pix_type;

endpackage

@@ hw/rtl/yuyv_to_rgb_converter.sv @@
// Throughput: one macropixel per clock; busy stays low, four register stages
// (offset, multiply, sum, clamp and select) run with valid bits alongside.
// Reset: synchronous, clears the stage valid bits and sets output_mode to RGB.
// Results cannot be held off; each is shown for exactly one cycle.
// ---------------------------------------------------------------------------
// yuyv_to_rgb_converter
// YUYV 4:2:2 macropixel to two RGB pixels, gray luma or passthrough bytes,
// selected by the output_mode register on an APB-style port.
// ---------------------------------------------------------------------------
module yuyv_to_rgb_converter (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   start,
   output logic                   busy,
   input  yrgb_pkg::yrgb_req_type req_data,
   // result channel
   output logic                   rsp_valid,
   output yrgb_pkg::yrgb_rsp_type rsp_data,
   // configuration port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [1:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import yrgb_pkg::*;

   logic [1:0]   mode_ff, mode_in;

   // stage 1: offsets applied
   logic              v1_ff, v1_in;
   logic [1:0]        m1_ff;
   yrgb_req_type      d1_ff;
   logic signed [8:0] y0_ff, y1_ff, u_ff, v_ff;
   // stages 2 and 3: side data alongside the matrix
   logic              v2_ff, v3_ff;
   logic [1:0]        m2_ff, m3_ff;
   yrgb_req_type      d2_ff, d3_ff;
   // output register
   logic              rsp_valid_ff;
   yrgb_rsp_type      rsp_data_ff, rsp_data_in;

   yrgb_pix_type      pix0, pix1;

   // configuration register, one word
   assign pready = 1'b1;
   assign prdata = {30'd0, mode_ff};
   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0)
         mode_in = pwdata[1:0];
      else if (psel && penable && pwrite && pready)
         mode_in = pwdata[1:0];
   end

   // never stalls
   assign busy  = 1'b0;
   assign v1_in = start && !busy;

   // control: valid bits and mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      m1_ff <= mode_ff;
      d1_ff <= req_data;
      y0_ff <= $signed({1'b0, req_data.luma_first})  - LUMA_OFS;
      y1_ff <= $signed({1'b0, req_data.luma_second}) - LUMA_OFS;
      u_ff  <= $signed({1'b0, req_data.chroma_blue}) - CHROMA_OFS;
      v_ff  <= $signed({1'b0, req_data.chroma_red})  - CHROMA_OFS;
      m2_ff <= m1_ff;
      d2_ff <= d1_ff;
      m3_ff <= m2_ff;
      d3_ff <= d2_ff;
      rsp_data_ff <= rsp_data_in;
   end

   // colour matrix, one per pixel of the macropixel
   yrgb_pixel u_pix0 (
      .clock (clock),
      .luma  (y0_ff),
      .cb    (u_ff),
      .cr    (v_ff),
      .pix   (pix0)
   );

   yrgb_pixel u_pix1 (
      .clock (clock),
      .luma  (y1_ff),
      .cb    (u_ff),
      .cr    (v_ff),
      .pix   (pix1)
   );

   // result select by mode; unused bytes zero
   always_comb begin
      rsp_data_in            = '0;
      rsp_data_in.frame_last = d3_ff.frame_end;
      case (m3_ff)
         MODE_PASS: begin
            rsp_data_in.out_byte0   = d3_ff.luma_first;
            rsp_data_in.out_byte1   = d3_ff.chroma_blue;
            rsp_data_in.out_byte2   = d3_ff.luma_second;
            rsp_data_in.out_byte3   = d3_ff.chroma_red;
            rsp_data_in.valid_count = COUNT_PASS;
         end
         MODE_RGB: begin
            rsp_data_in.out_byte0   = pix0.red;
            rsp_data_in.out_byte1   = pix0.green;
            rsp_data_in.out_byte2   = pix0.blue;
            rsp_data_in.out_byte3   = pix1.red;
            rsp_data_in.out_byte4   = pix1.green;
            rsp_data_in.out_byte5   = pix1.blue;
            rsp_data_in.valid_count = COUNT_RGB;
         end
         MODE_GRAY: begin
            rsp_data_in.out_byte0   = d3_ff.luma_first;
            rsp_data_in.out_byte1   = d3_ff.luma_second;
            rsp_data_in.valid_count = COUNT_GRAY;
         end
         default: begin
            rsp_data_in.valid_count = COUNT_NONE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every result comes from a matching input transfer
   a_rsp_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 4))
      else $error("result strobe without a matching input transfer");

   // byte count is one of the defined values
   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.valid_count == COUNT_NONE ||
                     rsp_data.valid_count == COUNT_GRAY ||
                     rsp_data.valid_count == COUNT_PASS ||
                     rsp_data.valid_count == COUNT_RGB))
      else $error("illegal valid_count");

   // bytes beyond the count are zero
   a_gray_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valid_count == COUNT_GRAY |->
         (rsp_data.out_byte2 == 8'd0 && rsp_data.out_byte3 == 8'd0 &&
          rsp_data.out_byte4 == 8'd0 && rsp_data.out_byte5 == 8'd0))
      else $error("gray result carries stray bytes");

   a_pass_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valid_count == COUNT_PASS |->
         (rsp_data.out_byte4 == 8'd0 && rsp_data.out_byte5 == 8'd0))
      else $error("passthrough result carries stray bytes");

endmodule

@@ hw/rtl/yrgb_pixel.sv @@
// ---------------------------------------------------------------------------
// yrgb_pixel
// Two-stage colour matrix for one pixel: constant products, then channel
// sums with rounding. Clamping to 0..255 follows the sum registers.
// ---------------------------------------------------------------------------
module yrgb_pixel (
   input  logic                  clock,
   input  logic signed [8:0]     luma,     // Y - 16
   input  logic signed [8:0]     cb,       // U - 128
   input  logic signed [8:0]     cr,       // V - 128
   output yrgb_pkg::yrgb_pix_type pix
);
   import yrgb_pkg::*;

   logic signed [SUM_W-1:0] py_ff,  py_in;
   logic signed [SUM_W-1:0] pvr_ff, pvr_in;
   logic signed [SUM_W-1:0] pug_ff, pug_in;
   logic signed [SUM_W-1:0] pvg_ff, pvg_in;
   logic signed [SUM_W-1:0] pub_ff, pub_in;
   logic signed [SUM_W-1:0] sr_ff,  sr_in;
   logic signed [SUM_W-1:0] sg_ff,  sg_in;
   logic signed [SUM_W-1:0] sb_ff,  sb_in;

   // negative sums clamp to zero, then shift by 8 and saturate
   function automatic logic [7:0] clamp_chan(input logic signed [SUM_W-1:0] acc);
      logic [SUM_W-10:0] q;
      q = acc[SUM_W-2:8];
      if (acc[SUM_W-1])
         return 8'd0;
      else if (q > (SUM_W-9)'(CHAN_MAX))
         return CHAN_MAX;
      else
         return q[7:0];
   endfunction

   // stage: constant products
   always_comb begin
      py_in  = SUM_W'(luma) * K_Y;
      pvr_in = SUM_W'(cr)   * K_VR;
      pug_in = SUM_W'(cb)   * K_UG;
      pvg_in = SUM_W'(cr)   * K_VG;
      pub_in = SUM_W'(cb)   * K_UB;
   end

   // stage: channel sums
   always_comb begin
      sr_in = py_ff + pvr_ff + ROUND;
      sg_in = py_ff - pug_ff - pvg_ff + ROUND;
      sb_in = py_ff + pub_ff + ROUND;
   end

   always_ff @(posedge clock) begin
      py_ff  <= py_in;
      pvr_ff <= pvr_in;
      pug_ff <= pug_in;
      pvg_ff <= pvg_in;
      pub_ff <= pub_in;
      sr_ff  <= sr_in;
      sg_ff  <= sg_in;
      sb_ff  <= sb_in;
   end

   assign pix.red   = clamp_chan(sr_ff);
   assign pix.green = clamp_chan(sg_ff);
   assign pix.blue  = clamp_chan(sb_ff);

endmodule
